// ----- design/mkcc_pkg.sv -----
// Shared types, codes and constants for the KCS channel controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mkcc_pkg;

  localparam logic [31:0] HDR_MAGIC       = 32'h4d43_5450;
  localparam logic [31:0] RX_BUFFER_BYTES = 32'd64;

  localparam int unsigned ST_BMC_READY_BIT  = 7;
  localparam int unsigned ST_CHAN_READY_BIT = 6;
  localparam int unsigned ST_OBF_BIT        = 0;

  // Incoming KCS data byte codes.
  localparam logic [7:0] KCS_DATA_TX_START    = 8'h01;
  localparam logic [7:0] KCS_DATA_RX_COMPLETE = 8'h02;

  typedef enum logic [1:0] {
    CHAN_IDLE = 2'd0,
    CHAN_INIT = 2'd1,
    CHAN_RUN  = 2'd2
  } chan_state_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_WR_VERSION = 3'd1,
    ACT_LATCH_WIN  = 3'd2,
    ACT_READ_RX    = 3'd3,
    ACT_DROP_RX    = 3'd4,
    ACT_WRITE_TX   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    MSG_INIT        = 2'd0,
    MSG_TX_START    = 2'd1,
    MSG_RX_COMPLETE = 2'd2
  } kcs_msg_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_BAD_MAGIC     = 3'd1,
    ERR_RX_OVER_WIN   = 3'd2,
    ERR_RX_OVER_BUF   = 3'd3,
    ERR_TX_NOT_RUN    = 3'd4,
    ERR_UNKNOWN_MSG   = 3'd5,
    ERR_INVALID_STATE = 3'd6
  } err_t;

  typedef enum logic {
    CMD_POLL = 1'b0,
    CMD_TX   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  kcs_status;
    logic [7:0]  kcs_data;
    logic [31:0] header_magic;
    logic [31:0] window_rx_size;
    logic [31:0] rx_length;
    logic [7:0]  tx_length;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic        kcs_send_valid;
    kcs_msg_t    kcs_message;
    logic        deliver_rx;
    chan_state_t channel_state_out;
    logic        tx_enabled_out;
    err_t        error_code;
  } result_t;

  // Channel state carried from one word to the next.
  typedef struct packed {
    chan_state_t chan;
    logic        tx_busy;
    logic        tx_enable;
    logic [31:0] rx_window_bytes;
  } ctx_t;

endpackage

// ----- design/mkcc_in_stage.sv -----
// Input register stage of the KCS channel controller: holds one accepted word.
// Depends on mkcc_pkg for the item type.
`timescale 1ns / 1ps

module mkcc_in_stage import mkcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_take,
  input  item_t in_item,
  input  logic  advance,
  output logic  hold_valid,
  output item_t hold_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b0;
    end
    if (in_take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// ----- design/mkcc_decide.sv -----
// Decision logic of the KCS channel controller: one word plus the channel
// state give the result fields and the next channel state. Depends on mkcc_pkg.
`timescale 1ns / 1ps

module mkcc_decide import mkcc_pkg::*; (
  input  item_t   item,
  input  ctx_t    ctx,
  output result_t res,
  output ctx_t    ctx_nxt
);

  logic bmc_up;
  logic chan_ready;
  logic obf;
  logic magic_ok;
  logic rx_over_win;
  logic rx_over_buf;

  assign bmc_up      = item.kcs_status[ST_BMC_READY_BIT];
  assign chan_ready  = item.kcs_status[ST_CHAN_READY_BIT];
  assign obf         = item.kcs_status[ST_OBF_BIT];
  assign magic_ok    = (item.header_magic == HDR_MAGIC);
  assign rx_over_buf = (item.rx_length > RX_BUFFER_BYTES);

  // The window compare uses the size latched in this same word when the
  // channel starts and a message arrives together.
  always_comb begin
    if (ctx.chan == CHAN_INIT) begin
      rx_over_win = (item.rx_length > item.window_rx_size);
    end else begin
      rx_over_win = (item.rx_length > ctx.rx_window_bytes);
    end
  end

  always_comb begin
    logic running;
    running             = 1'b0;
    ctx_nxt             = ctx;
    res.action          = ACT_NONE;
    res.kcs_send_valid  = 1'b0;
    res.kcs_message     = MSG_INIT;
    res.deliver_rx      = 1'b0;
    res.error_code      = ERR_NONE;

    if (item.cmd == CMD_TX) begin
      if (ctx.chan != CHAN_RUN) begin
        res.error_code = ERR_TX_NOT_RUN;
      end else begin
        res.action         = ACT_WRITE_TX;
        res.kcs_send_valid = 1'b1;
        res.kcs_message    = MSG_TX_START;
        ctx_nxt.tx_busy    = 1'b1;
        ctx_nxt.tx_enable  = 1'b0;
      end
    end else if (!bmc_up) begin
      ctx_nxt.chan = CHAN_IDLE;
    end else begin
      unique case (ctx.chan)
        CHAN_IDLE: begin
          if (!magic_ok) begin
            res.error_code = ERR_BAD_MAGIC;
          end else begin
            res.action         = ACT_WR_VERSION;
            res.kcs_send_valid = 1'b1;
            res.kcs_message    = MSG_INIT;
            ctx_nxt.chan       = CHAN_INIT;
          end
        end
        CHAN_INIT: begin
          if (chan_ready) begin
            ctx_nxt.rx_window_bytes = item.window_rx_size;
            ctx_nxt.chan            = CHAN_RUN;
            ctx_nxt.tx_enable       = 1'b1;
            res.action              = ACT_LATCH_WIN;
            running                 = 1'b1;
          end
        end
        CHAN_RUN: begin
          if (!chan_ready) begin
            // Channel reset by the BMC: restart negotiation.
            ctx_nxt.chan = CHAN_INIT;
            if (!magic_ok) begin
              res.error_code = ERR_BAD_MAGIC;
            end else begin
              res.action         = ACT_WR_VERSION;
              res.kcs_send_valid = 1'b1;
              res.kcs_message    = MSG_INIT;
            end
          end else begin
            running = 1'b1;
          end
        end
        default: begin
          res.error_code = ERR_INVALID_STATE;
          ctx_nxt.chan   = CHAN_IDLE;
        end
      endcase

      if (running && obf) begin
        if (item.kcs_data == KCS_DATA_TX_START) begin
          if (rx_over_win) begin
            res.action     = ACT_DROP_RX;
            res.error_code = ERR_RX_OVER_WIN;
          end else if (rx_over_buf) begin
            res.action     = ACT_DROP_RX;
            res.error_code = ERR_RX_OVER_BUF;
          end else begin
            res.action         = ACT_READ_RX;
            res.kcs_send_valid = 1'b1;
            res.kcs_message    = MSG_RX_COMPLETE;
            res.deliver_rx     = 1'b1;
          end
        end else if (item.kcs_data == KCS_DATA_RX_COMPLETE) begin
          ctx_nxt.tx_busy   = 1'b0;
          ctx_nxt.tx_enable = 1'b1;
        end else begin
          res.error_code = ERR_UNKNOWN_MSG;
        end
      end
    end

    res.channel_state_out = ctx_nxt.chan;
    res.tx_enabled_out    = ctx_nxt.tx_enable;
  end

endmodule

// ----- design/mctp_kcs_channel_controller_core.sv -----
// Top level of the host-side MCTP over KCS channel controller.
// Instantiates mkcc_in_stage and mkcc_decide; depends on mkcc_pkg.
`timescale 1ns / 1ps

// Each input word is either a KCS status poll or a transmit request, and
// each one produces exactly one result word. A word sits in an input
// register, the decision logic evaluates it against the channel state
// (idle, init, running, the tx-pending and tx-enable flags and the latched
// receive window size), and the result lands in an output register while
// the channel state is updated in the same cycle. With out_tready held high
// the block takes one word every clock cycle and returns each result
// via the input and then the output register; updating the channel state
// with the result lets the next word follow immediately. When the result
// register is full and not taken, the input register still accepts one
// more word, so the input side stalls only once both registers hold data.
// Bus transfers to the shared window and KCS registers are not performed
// here: the action and kcs_message fields tell the surrounding logic what
// to do. There are no configuration registers and no clearing pass after
// reset.

module mctp_kcs_channel_controller_core import mkcc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // From bit 0: kcs_status[7:0], kcs_data[15:8], header_magic[47:16],
  // window_rx_size[79:48], rx_length[111:80], tx_length[119:112].
  input  logic [119:0] in_tdata,
  // Bit 0: cmd (0 poll, 1 transmit request).
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // From bit 0: action[2:0], kcs_send_valid[3], kcs_message[5:4],
  // deliver_rx[6], channel_state_out[8:7], tx_enabled_out[9],
  // error_code[12:10], zero fill[15:13].
  output logic [15:0]  out_tdata
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    in_take;
  logic    advance;
  result_t res;
  ctx_t    ctx_r;
  ctx_t    ctx_nxt;
  result_t out_res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;

  // Unpack the input word.
  assign in_item.cmd            = cmd_t'(in_tuser);
  assign in_item.kcs_status     = in_tdata[7:0];
  assign in_item.kcs_data       = in_tdata[15:8];
  assign in_item.header_magic   = in_tdata[47:16];
  assign in_item.window_rx_size = in_tdata[79:48];
  assign in_item.rx_length      = in_tdata[111:80];
  assign in_item.tx_length      = in_tdata[119:112];

  // A held word moves on when the result register is empty or being drained.
  assign advance   = hold_valid && (!out_valid_r || out_tready);
  assign in_tready = !hold_valid || advance;
  assign in_take   = in_tvalid && in_tready;

  mkcc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  mkcc_decide u_decide (
    .item    (hold_item),
    .ctx     (ctx_r),
    .res     (res),
    .ctx_nxt (ctx_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Channel state and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.chan            <= CHAN_IDLE;
      ctx_r.tx_busy         <= 1'b0;
      ctx_r.tx_enable       <= 1'b0;
      ctx_r.rx_window_bytes <= 32'd0;
      out_valid_r           <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.error_code,
                       out_res_r.tx_enabled_out,
                       out_res_r.channel_state_out,
                       out_res_r.deliver_rx,
                       out_res_r.kcs_message,
                       out_res_r.kcs_send_valid,
                       out_res_r.action};

  // A delivered packet always comes with a read action and an RX_COMPLETE.
  a_deliver_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.deliver_rx) |->
      (out_res_r.action == ACT_READ_RX && out_res_r.kcs_send_valid &&
       out_res_r.kcs_message == MSG_RX_COMPLETE))
    else $error("deliver_rx without read action and RX_COMPLETE");

  // No KCS message goes out alongside an error.
  a_err_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error_code != ERR_NONE) |-> !out_res_r.kcs_send_valid)
    else $error("KCS message sent together with an error");

  // A transmit leaves tx-enable low and marks a transmit pending.
  a_tx_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.action == ACT_WRITE_TX) |=>
      (ctx_r.tx_busy && !ctx_r.tx_enable && ctx_r.chan == CHAN_RUN))
    else $error("transmit did not block further transmits");

  // The channel state register only changes when a word is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(ctx_r))
    else $error("channel state changed without a word");

endmodule
